### sv/mcu_pkg.sv
// Shared types and constants for the machine-mode CSR unit.
// No dependencies; used by mcu_csr_file and machine_csr_unit_core.
package mcu_pkg;

  typedef enum logic [1:0] {
    OP_RW    = 2'd0,
    OP_RS    = 2'd1,
    OP_ECALL = 2'd2,
    OP_MRET  = 2'd3
  } op_e;

  localparam logic [11:0] ADDR_MSTATUS = 12'h300;
  localparam logic [11:0] ADDR_MTVEC   = 12'h305;
  localparam logic [11:0] ADDR_MEPC    = 12'h341;
  localparam logic [11:0] ADDR_MCAUSE  = 12'h342;

  typedef struct packed {
    op_e         opcode;
    logic [11:0] reg_addr;
    logic [31:0] src1;
    logic [4:0]  rd;
    logic [31:0] pc;
    logic [31:0] cause_value;
  } req_t;

  typedef struct packed {
    logic [31:0] rd_value;
    logic        rd_write;
    logic        redirect;
    logic [31:0] next_pc;
    logic        illegal;
  } res_t;

endpackage

### sv/machine_csr_unit_core.sv
// Top level of the machine-mode CSR unit: input register, CSR file, result register.
// Depends on mcu_pkg and mcu_csr_file.
//
//  channel | signals                                          | dir
//  in      | in_valid_i/in_ready_o, opcode_i..cause_value_i   | in
//  out     | out_valid_o/out_ready_i, rd_value_o..illegal_o   | out
//
// One item per cycle unless the output stalls; the result is registered.
// The CSR update happens as the item leaves the input register, so the next item sees it.
// Reset clears the four CSRs and both valid flags.
// A stalled result holds the input register; input stalls only when both stages are full
// and the result is not taken in that cycle.
module machine_csr_unit_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [11:0] reg_addr_i,
  input  logic [31:0] src1_i,
  input  logic [4:0]  rd_i,
  input  logic [31:0] pc_i,
  input  logic [31:0] cause_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] rd_value_o,
  output logic        rd_write_o,
  output logic        redirect_o,
  output logic [31:0] next_pc_o,
  output logic        illegal_o
);

  logic          req_valid_q;
  mcu_pkg::req_t req_q;
  logic          res_valid_q;
  mcu_pkg::res_t res_q;
  mcu_pkg::res_t res_d;
  logic          exec;

  // item moves from input register to result register
  assign exec       = req_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !req_valid_q || exec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) req_valid_q <= in_valid_i;
      if (exec) begin
        res_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q.opcode      <= mcu_pkg::op_e'(opcode_i);
      req_q.reg_addr    <= reg_addr_i;
      req_q.src1        <= src1_i;
      req_q.rd          <= rd_i;
      req_q.pc          <= pc_i;
      req_q.cause_value <= cause_value_i;
    end
    if (exec) res_q <= res_d;
  end

  mcu_csr_file u_csr_file (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .exec_i (exec),
    .req_i  (req_q),
    .res_o  (res_d)
  );

  assign out_valid_o = res_valid_q;
  assign rd_value_o  = res_q.rd_value;
  assign rd_write_o  = res_q.rd_write;
  assign redirect_o  = res_q.redirect;
  assign next_pc_o   = res_q.next_pc;
  assign illegal_o   = res_q.illegal;

  a_illegal_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && illegal_o |-> !rd_write_o && !redirect_o && rd_value_o == 32'd0)
    else $error("illegal result carries other fields");

  a_redirect_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && redirect_o |-> !rd_write_o && !illegal_o)
    else $error("redirect result also writes rd");

  a_stall_holds_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q && !exec |=> req_valid_q && $stable(req_q))
    else $error("input register lost a stalled item");

endmodule

### sv/mcu_csr_file.sv
// CSR storage (mstatus, mtvec, mepc, mcause) and combinational operation logic.
// Depends on mcu_pkg for the request/result structs and address codes.
module mcu_csr_file (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          exec_i,
  input  mcu_pkg::req_t req_i,
  output mcu_pkg::res_t res_o
);

  logic [31:0] mstatus_q, mstatus_d;
  logic [31:0] mtvec_q, mtvec_d;
  logic [31:0] mepc_q, mepc_d;
  logic [31:0] mcause_q, mcause_d;

  logic        hit;
  logic [31:0] old_val;
  logic [31:0] new_val;
  logic        csr_op;

  always_comb begin
    hit     = 1'b1;
    old_val = '0;
    case (req_i.reg_addr)
      mcu_pkg::ADDR_MSTATUS: old_val = mstatus_q;
      mcu_pkg::ADDR_MTVEC:   old_val = mtvec_q;
      mcu_pkg::ADDR_MEPC:    old_val = mepc_q;
      mcu_pkg::ADDR_MCAUSE:  old_val = mcause_q;
      default:               hit = 1'b0;
    endcase
  end

  assign csr_op  = (req_i.opcode == mcu_pkg::OP_RW) || (req_i.opcode == mcu_pkg::OP_RS);
  assign new_val = (req_i.opcode == mcu_pkg::OP_RW) ? req_i.src1 : (old_val | req_i.src1);

  always_comb begin
    mstatus_d = mstatus_q;
    mtvec_d   = mtvec_q;
    mepc_d    = mepc_q;
    mcause_d  = mcause_q;
    res_o     = '0;
    case (req_i.opcode)
      mcu_pkg::OP_RW, mcu_pkg::OP_RS: begin
        if (hit) begin
          res_o.rd_value = old_val;
          res_o.rd_write = (req_i.rd != 5'd0);
          case (req_i.reg_addr)
            mcu_pkg::ADDR_MSTATUS: mstatus_d = new_val;
            mcu_pkg::ADDR_MTVEC:   mtvec_d   = new_val;
            mcu_pkg::ADDR_MEPC:    mepc_d    = new_val;
            mcu_pkg::ADDR_MCAUSE:  mcause_d  = new_val;
            default:               ;
          endcase
        end else begin
          res_o.illegal = 1'b1;
        end
      end
      mcu_pkg::OP_ECALL: begin
        mepc_d         = req_i.pc;
        mcause_d       = req_i.cause_value;
        res_o.next_pc  = mtvec_q;
        res_o.redirect = 1'b1;
      end
      mcu_pkg::OP_MRET: begin
        res_o.next_pc  = mepc_q;
        res_o.redirect = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mstatus_q <= '0;
      mtvec_q   <= '0;
      mepc_q    <= '0;
      mcause_q  <= '0;
    end else if (exec_i) begin
      mstatus_q <= mstatus_d;
      mtvec_q   <= mtvec_d;
      mepc_q    <= mepc_d;
      mcause_q  <= mcause_d;
    end
  end

  // unknown address on a CSR access must leave every register alone
  a_illegal_no_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_i && csr_op && !hit |=> $stable(mstatus_q) && $stable(mtvec_q)
      && $stable(mepc_q) && $stable(mcause_q))
    else $error("illegal CSR access changed state");

  a_ecall_saves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_i && req_i.opcode == mcu_pkg::OP_ECALL |=>
      mepc_q == $past(req_i.pc) && mcause_q == $past(req_i.cause_value))
    else $error("ecall did not save pc/cause");

  a_mret_no_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_i && req_i.opcode == mcu_pkg::OP_MRET |=> $stable(mstatus_q)
      && $stable(mtvec_q) && $stable(mepc_q) && $stable(mcause_q))
    else $error("mret changed state");

endmodule

### tb/sv/tb_machine_csr_unit_core.sv
// Self-checking testbench for machine_csr_unit_core: directed and random CSR operations
// with random stalls on both channels, checked against a local CSR predictor.
// Depends on mcu_pkg and the machine_csr_unit_core RTL.
module tb_machine_csr_unit_core;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [1:0]  opcode_i      = '0;
  logic [11:0] reg_addr_i    = '0;
  logic [31:0] src1_i        = '0;
  logic [4:0]  rd_i          = '0;
  logic [31:0] pc_i          = '0;
  logic [31:0] cause_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [31:0] rd_value_o;
  logic        rd_write_o;
  logic        redirect_o;
  logic [31:0] next_pc_o;
  logic        illegal_o;

  machine_csr_unit_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .reg_addr_i    (reg_addr_i),
    .src1_i        (src1_i),
    .rd_i          (rd_i),
    .pc_i          (pc_i),
    .cause_value_i (cause_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .rd_value_o    (rd_value_o),
    .rd_write_o    (rd_write_o),
    .redirect_o    (redirect_o),
    .next_pc_o     (next_pc_o),
    .illegal_o     (illegal_o)
  );

  always #1 clk_i = ~clk_i;

  // predicted CSR contents
  logic [31:0] mstatus_m = '0;
  logic [31:0] mtvec_m   = '0;
  logic [31:0] mepc_m    = '0;
  logic [31:0] mcause_m  = '0;

  mcu_pkg::req_t op_queue[$];
  mcu_pkg::res_t pending_outcomes[$];
  mcu_pkg::req_t cur_item     = '0;
  logic          in_taken     = 1'b0;
  int            send_gap_pct = 0;
  int            recv_gap_pct = 0;
  int            error_cnt    = 0;
  int            cycle_cnt    = 0;
  logic          stall_req    = 1'b0;
  logic          stall_ack    = 1'b0;
  int            stall_left   = 0;

  function automatic mcu_pkg::res_t csr_op_outcome(input mcu_pkg::req_t rq);
    mcu_pkg::res_t rs;
    logic [31:0]   old;
    logic [31:0]   upd;
    logic          hit;
    rs  = '0;
    old = '0;
    hit = 1'b1;
    case (rq.opcode)
      mcu_pkg::OP_RW, mcu_pkg::OP_RS: begin
        case (rq.reg_addr)
          mcu_pkg::ADDR_MSTATUS: old = mstatus_m;
          mcu_pkg::ADDR_MTVEC:   old = mtvec_m;
          mcu_pkg::ADDR_MEPC:    old = mepc_m;
          mcu_pkg::ADDR_MCAUSE:  old = mcause_m;
          default:               hit = 1'b0;
        endcase
        if (!hit) begin
          rs.illegal = 1'b1;
        end else begin
          upd = (rq.opcode == mcu_pkg::OP_RW) ? rq.src1 : (old | rq.src1);
          case (rq.reg_addr)
            mcu_pkg::ADDR_MSTATUS: mstatus_m = upd;
            mcu_pkg::ADDR_MTVEC:   mtvec_m   = upd;
            mcu_pkg::ADDR_MEPC:    mepc_m    = upd;
            mcu_pkg::ADDR_MCAUSE:  mcause_m  = upd;
            default: ;
          endcase
          rs.rd_value = old;
          rs.rd_write = (rq.rd != '0);
        end
      end
      mcu_pkg::OP_ECALL: begin
        mepc_m      = rq.pc;
        mcause_m    = rq.cause_value;
        rs.next_pc  = mtvec_m;
        rs.redirect = 1'b1;
      end
      default: begin
        rs.next_pc  = mepc_m;
        rs.redirect = 1'b1;
      end
    endcase
    return rs;
  endfunction

  function automatic mcu_pkg::req_t mk(input mcu_pkg::op_e op, input logic [11:0] addr,
                                       input logic [31:0] s, input logic [4:0] r,
                                       input logic [31:0] p, input logic [31:0] c);
    mcu_pkg::req_t rq;
    rq.opcode      = op;
    rq.reg_addr    = addr;
    rq.src1        = s;
    rq.rd          = r;
    rq.pc          = p;
    rq.cause_value = c;
    return rq;
  endfunction

  // mostly implemented addresses; some near misses and pure noise
  function automatic mcu_pkg::req_t random_csr_op();
    mcu_pkg::req_t rq;
    int            pick;
    rq.opcode      = mcu_pkg::op_e'($urandom_range(3));
    rq.rd          = ($urandom_range(99) < 15) ? 5'd0 : 5'($urandom);
    rq.pc          = $urandom;
    rq.cause_value = $urandom;
    pick = $urandom_range(99);
    if (pick < 10)      rq.src1 = '0;
    else if (pick < 20) rq.src1 = '1;
    else                rq.src1 = $urandom;
    pick = $urandom_range(99);
    if (pick < 85) begin
      case ($urandom_range(3))
        0: rq.reg_addr = mcu_pkg::ADDR_MSTATUS;
        1: rq.reg_addr = mcu_pkg::ADDR_MTVEC;
        2: rq.reg_addr = mcu_pkg::ADDR_MEPC;
        default: rq.reg_addr = mcu_pkg::ADDR_MCAUSE;
      endcase
    end else if (pick < 95) begin
      case ($urandom_range(7))
        0: rq.reg_addr = mcu_pkg::ADDR_MSTATUS + 12'd1;
        1: rq.reg_addr = mcu_pkg::ADDR_MTVEC - 12'd1;
        2: rq.reg_addr = mcu_pkg::ADDR_MTVEC + 12'd1;
        3: rq.reg_addr = mcu_pkg::ADDR_MEPC - 12'd1;
        4: rq.reg_addr = mcu_pkg::ADDR_MCAUSE + 12'd1;
        5: rq.reg_addr = mcu_pkg::ADDR_MSTATUS ^ 12'h800;
        6: rq.reg_addr = 12'h000;
        default: rq.reg_addr = 12'hFFF;
      endcase
    end else begin
      rq.reg_addr = 12'($urandom);
    end
    return rq;
  endfunction

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, fname, want, got);
      error_cnt++;
    end
  endtask

  // driver: new transfer offered only once the previous one went through
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (op_queue.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
        cur_item      <= op_queue[0];
        in_valid_i    <= 1'b1;
        opcode_i      <= op_queue[0].opcode;
        reg_addr_i    <= op_queue[0].reg_addr;
        src1_i        <= op_queue[0].src1;
        rd_i          <= op_queue[0].rd;
        pc_i          <= op_queue[0].pc;
        cause_value_i <= op_queue[0].cause_value;
        void'(op_queue.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random back-pressure plus one long hold when requested
  always @(negedge clk_i) begin
    if (stall_req && !stall_ack) begin
      stall_ack   <= 1'b1;
      stall_left  <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // monitor: check results first, then predict the transfer taken at this edge
  always @(posedge clk_i) begin
    mcu_pkg::res_t want;
    in_taken <= in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_outcomes.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual rd_value %h next_pc %h",
                   $time, rd_value_o, next_pc_o);
          error_cnt++;
        end else begin
          want = pending_outcomes.pop_front();
          check_field("rd_value", want.rd_value, rd_value_o);
          check_field("rd_write", 32'(want.rd_write), 32'(rd_write_o));
          check_field("redirect", 32'(want.redirect), 32'(redirect_o));
          check_field("next_pc", want.next_pc, next_pc_o);
          check_field("illegal", 32'(want.illegal), 32'(illegal_o));
        end
      end
      if (in_valid_i && in_ready_o) pending_outcomes.push_back(csr_op_outcome(cur_item));
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic wait_all_retired();
    while (op_queue.size() != 0 || in_valid_i || pending_outcomes.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    send_gap_pct = 7;
    recv_gap_pct = 49;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset values, extremes, dest zero, zero OR, illegal addresses
    op_queue.push_back(mk(mcu_pkg::OP_MRET, 12'h000, 32'h0, 5'd0, 32'h0, 32'h0));
    op_queue.push_back(mk(mcu_pkg::OP_ECALL, 12'h000, 32'h0, 5'd0, '1, '1));
    op_queue.push_back(mk(mcu_pkg::OP_RS, mcu_pkg::ADDR_MEPC, 32'h0, 5'd0, 32'h0, 32'h0));
    op_queue.push_back(mk(mcu_pkg::OP_RW, mcu_pkg::ADDR_MTVEC, '1, 5'd31, 32'h0, 32'h0));
    op_queue.push_back(mk(mcu_pkg::OP_ECALL, 12'hFFF, '1, 5'd31, 32'h0, 32'h0));
    op_queue.push_back(mk(mcu_pkg::OP_RS, mcu_pkg::ADDR_MCAUSE, 32'h0, 5'd1, 32'h0, 32'h0));
    op_queue.push_back(mk(mcu_pkg::OP_RW, mcu_pkg::ADDR_MSTATUS, 32'hA5A5_A5A5, 5'd1,
                          32'h0, 32'h0));
    op_queue.push_back(mk(mcu_pkg::OP_RS, mcu_pkg::ADDR_MSTATUS, 32'h5A5A_5A5A, 5'd0,
                          32'h0, 32'h0));
    op_queue.push_back(mk(mcu_pkg::OP_RW, mcu_pkg::ADDR_MSTATUS, 32'h0, 5'd5,
                          32'h0, 32'h0));
    op_queue.push_back(mk(mcu_pkg::OP_RS, mcu_pkg::ADDR_MCAUSE, 32'h8000_0000, 5'd3,
                          32'h0, 32'h0));
    op_queue.push_back(mk(mcu_pkg::OP_RW, mcu_pkg::ADDR_MEPC, 32'h1234_5678, 5'd31,
                          32'h0, 32'h0));
    op_queue.push_back(mk(mcu_pkg::OP_MRET, mcu_pkg::ADDR_MEPC, '1, 5'd31, '1, '1));
    op_queue.push_back(mk(mcu_pkg::OP_RW, 12'h000, '1, 5'd31, 32'h0, 32'h0));
    op_queue.push_back(mk(mcu_pkg::OP_RS, 12'hFFF, '1, 5'd31, 32'h0, 32'h0));
    op_queue.push_back(mk(mcu_pkg::OP_RW, mcu_pkg::ADDR_MSTATUS + 12'd1, '1, 5'd2,
                          32'h0, 32'h0));
    op_queue.push_back(mk(mcu_pkg::OP_RS, mcu_pkg::ADDR_MCAUSE + 12'd1, '1, 5'd0,
                          32'h0, 32'h0));
    op_queue.push_back(mk(mcu_pkg::OP_RW, mcu_pkg::ADDR_MCAUSE, '1, 5'd31, 32'h0, 32'h0));
    op_queue.push_back(mk(mcu_pkg::OP_RS, mcu_pkg::ADDR_MTVEC, 32'h0, 5'd31, 32'h0, 32'h0));
    op_queue.push_back(mk(mcu_pkg::OP_ECALL, mcu_pkg::ADDR_MSTATUS, '1, 5'd31,
                          32'hDEAD_BEEC, 32'h0000_005D));
    op_queue.push_back(mk(mcu_pkg::OP_MRET, 12'h000, 32'h0, 5'd0, 32'h0, 32'h0));
    op_queue.push_back(mk(mcu_pkg::OP_RW, mcu_pkg::ADDR_MEPC, 32'h0, 5'd31, 32'h0, 32'h0));
    op_queue.push_back(mk(mcu_pkg::OP_RW, mcu_pkg::ADDR_MSTATUS, '1, 5'd31, 32'h0, 32'h0));
    for (int i = 0; i < 130; i++) op_queue.push_back(random_csr_op());
    wait_all_retired();

    // slow sender, fast receiver, with one long receive hold to back up the pipe
    send_gap_pct = 49;
    recv_gap_pct = 7;
    stall_req    = 1'b1;
    for (int i = 0; i < 130; i++) op_queue.push_back(random_csr_op());
    wait_all_retired();

    send_gap_pct = 0;
    recv_gap_pct = 0;
    for (int i = 0; i < 140; i++) op_queue.push_back(random_csr_op());
    wait_all_retired();

    repeat (10) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
